// ===== hdl/framed_message_ring_buffer_assert.svh =====
// assertion macros for the framed message ring buffer
// each macro assumes signals named clk and rst_n in the calling module
`ifndef FRAMED_MESSAGE_RING_BUFFER_ASSERT_SVH
`define FRAMED_MESSAGE_RING_BUFFER_ASSERT_SVH
`ifndef SYNTH
`define FMRB_ASSERT_IMPLY(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("fmrb assertion failed");
`define FMRB_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("fmrb assertion failed");
`else
`define FMRB_ASSERT_IMPLY(label, cond, prop)
`define FMRB_ASSERT_NEXT(label, cond, prop)
`endif
`endif

// ===== hdl/fmrb_pkg.sv =====
`timescale 1ns / 1ps
package fmrb_pkg;

    localparam int LEN_W = 11;

    localparam logic [1:0] CMD_BEGIN_PUT  = 2'd0;
    localparam logic [1:0] CMD_PUT_DATA   = 2'd1;
    localparam logic [1:0] CMD_GET_HEADER = 2'd2;
    localparam logic [1:0] CMD_GET_BYTE   = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_TOO_LONG  = 3'd1;
    localparam logic [2:0] ST_NO_SPACE  = 3'd2;
    localparam logic [2:0] ST_EMPTY     = 3'd3;
    localparam logic [2:0] ST_SEQ_ERROR = 3'd4;

    localparam logic [LEN_W-1:0] MAX_BYTES = 11'h400;
    localparam logic [LEN_W-1:0] MAX_WORDS = 11'h200;
    localparam logic [3:0]       HDR_PAD   = 4'd5;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [2:0]       frame_kind;
        logic             word_mode;
        logic [LEN_W-1:0] length;
        logic [15:0]      data_word;
    } in_item_t;

    typedef struct packed {
        logic [2:0]       status;
        logic [2:0]       frame_kind_out;
        logic [LEN_W-1:0] length_out;
        logic [7:0]       data_byte;
        logic             last;
        logic             host_interrupt;
    } out_item_t;

endpackage

// ===== hdl/fmrb_store.sv =====
`timescale 1ns / 1ps
module fmrb_store #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [15:0]   wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [15:0]   rd_data
);

    logic [15:0] mem [DEPTH];
    logic [15:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/fmrb_out_stage.sv =====
`timescale 1ns / 1ps
module fmrb_out_stage
    import fmrb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  out_item_t load_item,
    output logic      free,
    output logic      rsp_valid,
    output out_item_t rsp_item,
    input  logic      rsp_stall
);

    logic      valid_reg;
    logic      valid_next;
    out_item_t item_reg;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (rsp_stall)
        begin
            valid_next = valid_reg;
        end
        else
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= load_item;
        end
    end

    assign free      = !valid_reg || !rsp_stall;
    assign rsp_valid = valid_reg;
    assign rsp_item  = item_reg;

endmodule

// ===== hdl/fmrb_ctrl.sv =====
`timescale 1ns / 1ps
`include "framed_message_ring_buffer_assert.svh"
module fmrb_ctrl
    import fmrb_pkg::*;
#(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_stall,
    input  in_item_t      cmd_item,
    input  logic          out_free,
    output logic          res_load,
    output out_item_t     res_item,
    output logic          wr_en,
    output logic [AW-1:0] wr_addr,
    output logic [15:0]   wr_data,
    output logic          rd_en,
    output logic [AW-1:0] rd_addr,
    input  logic [15:0]   rd_data
);

    localparam logic [AW-1:0] LAST_IDX  = AW'(DEPTH - 1);
    localparam logic [AW:0]   DEPTH_V   = (AW + 1)'(DEPTH);
    localparam logic [AW+1:0] SPACE_LIM = (AW + 2)'(DEPTH - 1);

    function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
        logic [AW-1:0] r;
        r = (p == LAST_IDX) ? '0 : p + AW'(1);
        return r;
    endfunction

    logic             busy_reg;
    in_item_t         item_reg;
    logic [AW-1:0]    read_pointer_reg, read_pointer_next;
    logic [AW-1:0]    write_pointer_reg, write_pointer_next;
    logic [AW-1:0]    put_cursor_reg, put_cursor_next;
    logic [LEN_W-1:0] put_remaining_reg, put_remaining_next;
    logic             put_active_reg, put_active_next;
    logic             put_in_words_reg, put_in_words_next;
    logic [7:0]       held_high_byte_reg, held_high_byte_next;
    logic             high_byte_waiting_reg, high_byte_waiting_next;
    logic [AW-1:0]    get_cursor_reg, get_cursor_next;
    logic [LEN_W-1:0] get_remaining_reg, get_remaining_next;
    logic [AW-1:0]    get_end_pointer_reg, get_end_pointer_next;
    logic             get_low_phase_reg, get_low_phase_next;

    logic             accept;
    logic [AW:0]      used;
    logic [LEN_W-1:0] words;
    logic [AW+1:0]    need;
    logic [LEN_W-1:0] hdr_count;
    logic [LEN_W-1:0] cnt;
    logic [LEN_W:0]   cnt_p1;
    logic [AW:0]      end_sum;
    logic [AW:0]      end_wrap;
    logic [AW-1:0]    end_ptr;
    logic [LEN_W-1:0] want;
    logic [AW-1:0]    cursor_adv;

    assign accept    = cmd_valid && !cmd_stall;
    assign cmd_stall = busy_reg || !out_free;
    assign rd_en     = accept;
    assign rd_addr   = (cmd_item.cmd == CMD_GET_HEADER) ? read_pointer_reg : get_cursor_reg;
    assign res_load  = busy_reg;

    always_comb
    begin
        if (write_pointer_reg >= read_pointer_reg)
        begin
            used = {1'b0, write_pointer_reg} - {1'b0, read_pointer_reg};
        end
        else
        begin
            used = {1'b0, write_pointer_reg} + DEPTH_V - {1'b0, read_pointer_reg};
        end
        words = item_reg.word_mode ? item_reg.length : {1'b0, item_reg.length[LEN_W-1:1]};
        need  = {1'b0, used} + (AW + 2)'(words) + (AW + 2)'(HDR_PAD);
        hdr_count = item_reg.word_mode ? {item_reg.length[LEN_W-2:0], 1'b0}
                                       : item_reg.length;
        cnt      = rd_data[LEN_W-1:0];
        cnt_p1   = {1'b0, cnt} + (LEN_W + 1)'(1);
        end_sum  = {1'b0, read_pointer_reg} + (AW + 1)'(1) + (AW + 1)'(cnt_p1[LEN_W:1]);
        end_wrap = end_sum - DEPTH_V;
        end_ptr  = (end_sum >= DEPTH_V) ? end_wrap[AW-1:0] : end_sum[AW-1:0];
        want     = (cnt < item_reg.length) ? cnt : item_reg.length;
        cursor_adv = ring_next(put_cursor_reg);
    end

    always_comb
    begin
        read_pointer_next      = read_pointer_reg;
        write_pointer_next     = write_pointer_reg;
        put_cursor_next        = put_cursor_reg;
        put_remaining_next     = put_remaining_reg;
        put_active_next        = put_active_reg;
        put_in_words_next      = put_in_words_reg;
        held_high_byte_next    = held_high_byte_reg;
        high_byte_waiting_next = high_byte_waiting_reg;
        get_cursor_next        = get_cursor_reg;
        get_remaining_next     = get_remaining_reg;
        get_end_pointer_next   = get_end_pointer_reg;
        get_low_phase_next     = get_low_phase_reg;
        wr_en    = 1'b0;
        wr_addr  = put_cursor_reg;
        wr_data  = item_reg.data_word;
        res_item = '0;

        if (busy_reg)
        begin
            unique case (item_reg.cmd)
                CMD_BEGIN_PUT:
                begin
                    if (put_active_reg)
                    begin
                        res_item.status = ST_SEQ_ERROR;
                    end
                    else if (item_reg.length > (item_reg.word_mode ? MAX_WORDS : MAX_BYTES))
                    begin
                        res_item.status = ST_TOO_LONG;
                    end
                    else if (need >= SPACE_LIM)
                    begin
                        res_item.status = ST_NO_SPACE;
                    end
                    else
                    begin
                        wr_en   = 1'b1;
                        wr_addr = write_pointer_reg;
                        wr_data = {1'b0, item_reg.frame_kind, 1'b0, hdr_count};
                        put_cursor_next        = ring_next(write_pointer_reg);
                        put_remaining_next     = item_reg.length;
                        put_in_words_next      = item_reg.word_mode;
                        held_high_byte_next    = 8'h00;
                        high_byte_waiting_next = 1'b0;
                        if (item_reg.length == '0)
                        begin
                            write_pointer_next      = ring_next(write_pointer_reg);
                            res_item.host_interrupt = 1'b1;
                        end
                        else
                        begin
                            put_active_next = 1'b1;
                        end
                    end
                end
                CMD_PUT_DATA:
                begin
                    if (!put_active_reg || put_remaining_reg == '0)
                    begin
                        res_item.status = ST_SEQ_ERROR;
                    end
                    else
                    begin
                        if (put_in_words_reg)
                        begin
                            wr_en           = 1'b1;
                            put_cursor_next = cursor_adv;
                        end
                        else if (!high_byte_waiting_reg)
                        begin
                            held_high_byte_next    = item_reg.data_word[7:0];
                            high_byte_waiting_next = 1'b1;
                            if (put_remaining_reg == LEN_W'(1))
                            begin
                                wr_en   = 1'b1;
                                wr_data = {item_reg.data_word[7:0], 8'h00};
                                put_cursor_next        = cursor_adv;
                                high_byte_waiting_next = 1'b0;
                            end
                        end
                        else
                        begin
                            wr_en   = 1'b1;
                            wr_data = {held_high_byte_reg, item_reg.data_word[7:0]};
                            put_cursor_next        = cursor_adv;
                            high_byte_waiting_next = 1'b0;
                        end
                        put_remaining_next = put_remaining_reg - LEN_W'(1);
                        if (put_remaining_reg == LEN_W'(1))
                        begin
                            write_pointer_next      = put_cursor_next;
                            put_active_next         = 1'b0;
                            res_item.host_interrupt = 1'b1;
                        end
                    end
                end
                CMD_GET_HEADER:
                begin
                    if (get_remaining_reg != '0)
                    begin
                        res_item.status = ST_SEQ_ERROR;
                    end
                    else if (read_pointer_reg == write_pointer_reg)
                    begin
                        res_item.status = ST_EMPTY;
                    end
                    else
                    begin
                        res_item.frame_kind_out = rd_data[14:12];
                        res_item.length_out     = cnt;
                        get_cursor_next       = ring_next(read_pointer_reg);
                        get_end_pointer_next  = end_ptr;
                        get_remaining_next    = want;
                        get_low_phase_next    = 1'b0;
                        if (want == '0)
                        begin
                            read_pointer_next = end_ptr;
                            res_item.last     = 1'b1;
                        end
                    end
                end
                CMD_GET_BYTE:
                begin
                    if (get_remaining_reg == '0)
                    begin
                        res_item.status = ST_SEQ_ERROR;
                    end
                    else
                    begin
                        if (!get_low_phase_reg)
                        begin
                            res_item.data_byte = rd_data[15:8];
                            get_low_phase_next = 1'b1;
                        end
                        else
                        begin
                            res_item.data_byte = rd_data[7:0];
                            get_low_phase_next = 1'b0;
                            get_cursor_next    = ring_next(get_cursor_reg);
                        end
                        get_remaining_next = get_remaining_reg - LEN_W'(1);
                        if (get_remaining_reg == LEN_W'(1))
                        begin
                            read_pointer_next  = get_end_pointer_reg;
                            get_low_phase_next = 1'b0;
                            res_item.last      = 1'b1;
                        end
                    end
                end
                default:
                begin
                    res_item.status = ST_SEQ_ERROR;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg              <= 1'b0;
            read_pointer_reg      <= '0;
            write_pointer_reg     <= '0;
            put_cursor_reg        <= '0;
            put_remaining_reg     <= '0;
            put_active_reg        <= 1'b0;
            put_in_words_reg      <= 1'b0;
            held_high_byte_reg    <= '0;
            high_byte_waiting_reg <= 1'b0;
            get_cursor_reg        <= '0;
            get_remaining_reg     <= '0;
            get_end_pointer_reg   <= '0;
            get_low_phase_reg     <= 1'b0;
        end
        else
        begin
            busy_reg              <= accept;
            read_pointer_reg      <= read_pointer_next;
            write_pointer_reg     <= write_pointer_next;
            put_cursor_reg        <= put_cursor_next;
            put_remaining_reg     <= put_remaining_next;
            put_active_reg        <= put_active_next;
            put_in_words_reg      <= put_in_words_next;
            held_high_byte_reg    <= held_high_byte_next;
            high_byte_waiting_reg <= high_byte_waiting_next;
            get_cursor_reg        <= get_cursor_next;
            get_remaining_reg     <= get_remaining_next;
            get_end_pointer_reg   <= get_end_pointer_next;
            get_low_phase_reg     <= get_low_phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= cmd_item;
        end
    end

    `FMRB_ASSERT_NEXT(a_accept_then_busy, accept, busy_reg)
    `FMRB_ASSERT_IMPLY(a_no_accept_when_busy, busy_reg, !accept)
    `FMRB_ASSERT_IMPLY(a_write_only_in_execute, wr_en, busy_reg)
    `FMRB_ASSERT_IMPLY(a_irq_only_on_ok, res_load && res_item.host_interrupt,
                       res_item.status == ST_OK)
    `FMRB_ASSERT_IMPLY(a_low_phase_has_bytes, get_low_phase_reg, get_remaining_reg != '0)

endmodule

// ===== hdl/framed_message_ring_buffer.sv =====
// an accepted command is registered and executed; its result is held in the output register
// the store is read on acceptance, ahead of execute; no new item is accepted while one executes
// the next item may be accepted while a result waits, as long as the result register frees
// reset: asynchronous active low, clears pointers, cursors and counters to zero
// the message store is not cleared; entries are defined once written
`timescale 1ns / 1ps
module framed_message_ring_buffer
    import fmrb_pkg::*;
#(
    parameter int DEPTH = 2048
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_stall,
    input  in_item_t  cmd_item,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output out_item_t rsp_item
);

    localparam int AW = $clog2(DEPTH);

    logic          out_free;
    logic          res_load;
    out_item_t     res_item;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [15:0]   wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [15:0]   rd_data;

    fmrb_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    fmrb_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_item  (cmd_item),
        .out_free  (out_free),
        .res_load  (res_load),
        .res_item  (res_item),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    fmrb_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_load),
        .load_item (res_item),
        .free      (out_free),
        .rsp_valid (rsp_valid),
        .rsp_item  (rsp_item),
        .rsp_stall (rsp_stall)
    );

endmodule
